// ===== sv/point_rotation_about_center_macros.svh =====
// Assertion macros used by the point rotation top level.
`ifndef POINT_ROTATION_ABOUT_CENTER_MACROS_SVH
`define POINT_ROTATION_ABOUT_CENTER_MACROS_SVH

// Checked only while out of reset.
`define PRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PRA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pra_pkg.sv =====
// Types, constants and tables for the point rotation block.
`default_nettype none

package pra_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int MAX_STAGES        = 32;
  localparam int TURN_DIV          = 45;

  // K = 0.60725293500888 in Q30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // 92 turns, in units of 2^19, keeps the upper angle bits non-negative
  localparam logic [13:0] TURN_OFS = 14'd4140;
  localparam logic [10:0] RCP45_LO = 11'd1456;      // floor(2^16/45)
  localparam logic [24:0] RCP45_HI = 25'd23860929;  // floor(2^30/45)
  localparam logic [5:0]  DIV45    = 6'd45;

  localparam logic signed [31:0] FOLD_LIM = 32'sd1073741824;
  localparam logic signed [38:0] SAT_MAX  = 39'sd2147483647;
  localparam logic signed [38:0] SAT_MIN  = -39'sd2147483648;
  localparam logic signed [31:0] RES_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [31:0] RES_MIN  = 32'sh80000000;

  typedef logic [31:0] atan_tbl_t [MAX_STAGES];

  // atan(2^-i) in binary-angle units (2^32 per turn)
  localparam atan_tbl_t ATAN_TBL = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef logic [12:0] frac_tbl_t [TURN_DIV];

  // floor((w*8192 + 22) / 45): binary-angle part of a residue w mod 45
  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int i = 0; i < TURN_DIV; i++) begin
      t[i] = 13'((i * 8192 + 22) / TURN_DIV);
    end
    return t;
  endfunction

  localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } geo_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic               flip;
    geo_t               geo;
  } ang_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
    geo_t               geo;
  } crd_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic               saturated;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/pra_chan_if.sv =====
// Input and result channel interfaces of the point rotation block.
`default_nettype none

interface pra_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] angle_deg;

  modport source (output valid, point_x, point_y, center_x, center_y, angle_deg,
                  input ready);
  modport sink (input valid, point_x, point_y, center_x, center_y, angle_deg,
                output ready);
endinterface

interface pra_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotated_x;
  logic signed [31:0] rotated_y;
  logic               saturated;

  modport source (output valid, rotated_x, rotated_y, saturated, input ready);
  modport sink (input valid, rotated_x, rotated_y, saturated, output ready);
endinterface

`default_nettype wire

// ===== sv/pra_angle.sv =====
// Angle front end: degrees mod 360 to binary angle, quadrant fold.
`default_nettype none

module pra_angle (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] angle_deg,
  input  wire pra_pkg::geo_t      in_geo,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pra_pkg::ang_t           out_ang
);

  localparam int NS = 7;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;

  pra_pkg::geo_t geo_r [NS];

  logic [13:0]        a1_qh_r;
  logic [18:0]        a1_lo_r;
  logic [13:0]        a2_qh_r;
  logic [8:0]         a2_est_r;
  logic [18:0]        a2_lo_r;
  logic [24:0]        a3_rem_r;
  logic [24:0]        a4_rem_r;
  logic [18:0]        a4_qe_r;
  logic [18:0]        a5_u_r;
  logic [5:0]         a5_w_r;
  logic signed [31:0] a6_b_r;
  logic signed [31:0] a7_z_r;
  logic               a7_flip_r;

  logic [13:0]        qh_nxt;
  logic [24:0]        prod_lo;
  logic [13:0]        q45_lo;
  logic [13:0]        diff_lo;
  logic [5:0]         m_nxt;
  logic [49:0]        prod_hi;
  logic [24:0]        q45_hi;
  logic [24:0]        diff_hi;
  logic [18:0]        u_nxt;
  logic [5:0]         w_nxt;
  logic signed [31:0] b_nxt;
  logic               flip_nxt;
  logic signed [31:0] z_nxt;

  // stall only where the stage ahead is full and blocked
  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = rdy[0];

  always_comb begin
    qh_nxt  = {angle_deg[31], angle_deg[31:19]} + pra_pkg::TURN_OFS;
    prod_lo = 25'(a1_qh_r) * 25'(pra_pkg::RCP45_LO);

    q45_lo  = 14'(a2_est_r) * 14'(pra_pkg::DIV45);
    diff_lo = a2_qh_r - q45_lo;
    if (diff_lo[6:0] >= 7'(pra_pkg::DIV45)) begin
      m_nxt = 6'(diff_lo[6:0] - 7'(pra_pkg::DIV45));
    end else begin
      m_nxt = diff_lo[5:0];
    end

    prod_hi = 50'(a3_rem_r) * 50'(pra_pkg::RCP45_HI);

    q45_hi  = 25'(a4_qe_r) * 25'(pra_pkg::DIV45);
    diff_hi = a4_rem_r - q45_hi;
    if (diff_hi[6:0] >= 7'(pra_pkg::DIV45)) begin
      w_nxt = 6'(diff_hi[6:0] - 7'(pra_pkg::DIV45));
      u_nxt = a4_qe_r + 19'd1;
    end else begin
      w_nxt = diff_hi[5:0];
      u_nxt = a4_qe_r;
    end

    b_nxt = $signed({a5_u_r, 13'd0} + {19'd0, pra_pkg::FRAC_TBL[a5_w_r]});

    // +-2^31 is an MSB flip mod 2^32
    flip_nxt = (a6_b_r > pra_pkg::FOLD_LIM) || (a6_b_r < -pra_pkg::FOLD_LIM);
    z_nxt    = flip_nxt ? $signed({~a6_b_r[31], a6_b_r[30:0]}) : a6_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      geo_r[0] <= in_geo;
      a1_qh_r  <= qh_nxt;
      a1_lo_r  <= angle_deg[18:0];
    end
    if (rdy[1]) begin
      geo_r[1] <= geo_r[0];
      a2_qh_r  <= a1_qh_r;
      a2_est_r <= prod_lo[24:16];
      a2_lo_r  <= a1_lo_r;
    end
    if (rdy[2]) begin
      geo_r[2] <= geo_r[1];
      a3_rem_r <= {m_nxt, a2_lo_r};
    end
    if (rdy[3]) begin
      geo_r[3] <= geo_r[2];
      a4_rem_r <= a3_rem_r;
      a4_qe_r  <= prod_hi[48:30];
    end
    if (rdy[4]) begin
      geo_r[4] <= geo_r[3];
      a5_u_r   <= u_nxt;
      a5_w_r   <= w_nxt;
    end
    if (rdy[5]) begin
      geo_r[5] <= geo_r[4];
      a6_b_r   <= b_nxt;
    end
    if (rdy[6]) begin
      geo_r[6]  <= geo_r[5];
      a7_z_r    <= z_nxt;
      a7_flip_r <= flip_nxt;
    end
  end

  assign out_valid    = v_r[NS-1];
  assign out_ang.z    = a7_z_r;
  assign out_ang.flip = a7_flip_r;
  assign out_ang.geo  = geo_r[NS-1];

endmodule

`default_nettype wire

// ===== sv/pra_cordic_cell.sv =====
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE).
`default_nettype none

module pra_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pra_pkg::crd_t in_d,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pra_pkg::crd_t      out_d
);

  logic               v_r;
  pra_pkg::crd_t      d_r;
  pra_pkg::crd_t      d_nxt;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] at;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    xs    = $signed(in_d.x) >>> STAGE;
    ys    = $signed(in_d.y) >>> STAGE;
    at    = $signed({1'b0, pra_pkg::ATAN_TBL[STAGE]});
    d_nxt = in_d;
    if (!in_d.z[32]) begin
      d_nxt.x = in_d.x - ys;
      d_nxt.y = in_d.y + xs;
      d_nxt.z = in_d.z - at;
    end else begin
      d_nxt.x = in_d.x + ys;
      d_nxt.y = in_d.y - xs;
      d_nxt.z = in_d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_d     = d_r;

endmodule

`default_nettype wire

// ===== sv/pra_rotate.sv =====
// Rotation back end: cos/sin rounding, products, sums, rounding, center add, clip.
`default_nettype none

module pra_rotate (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pra_pkg::crd_t in_d,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pra_pkg::res_t      out_d
);

  localparam int NS = 5;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;

  pra_pkg::geo_t geo_r [NS];

  logic signed [31:0] r1_c_r;
  logic signed [31:0] r1_s_r;
  logic signed [64:0] r2_cdx_r;
  logic signed [64:0] r2_sdy_r;
  logic signed [64:0] r2_cdy_r;
  logic signed [64:0] r2_sdx_r;
  logic signed [65:0] r3_sx_r;
  logic signed [65:0] r3_sy_r;
  logic signed [37:0] r4_tx_r;
  logic signed [37:0] r4_ty_r;
  pra_pkg::res_t      r5_res_r;

  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] c34;
  logic signed [33:0] s34;
  logic signed [65:0] sxr;
  logic signed [65:0] syr;
  logic signed [38:0] vx;
  logic signed [38:0] vy;
  pra_pkg::res_t      res_nxt;

  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_ready = rdy[0];

  always_comb begin
    xf  = in_d.flip ? -in_d.x : in_d.x;
    yf  = in_d.flip ? -in_d.y : in_d.y;
    c34 = (xf + 34'sd2) >>> 2;
    s34 = (yf + 34'sd2) >>> 2;

    sxr = (r3_sx_r + 66'sd134217728) >>> 28;
    syr = (r3_sy_r + 66'sd134217728) >>> 28;

    vx = 39'(r4_tx_r) + 39'(geo_r[3].cx);
    vy = 39'(r4_ty_r) + 39'(geo_r[3].cy);

    res_nxt.saturated = 1'b0;
    if (vx > pra_pkg::SAT_MAX) begin
      res_nxt.rotated_x = pra_pkg::RES_MAX;
      res_nxt.saturated = 1'b1;
    end else if (vx < pra_pkg::SAT_MIN) begin
      res_nxt.rotated_x = pra_pkg::RES_MIN;
      res_nxt.saturated = 1'b1;
    end else begin
      res_nxt.rotated_x = $signed(vx[31:0]);
    end
    if (vy > pra_pkg::SAT_MAX) begin
      res_nxt.rotated_y = pra_pkg::RES_MAX;
      res_nxt.saturated = 1'b1;
    end else if (vy < pra_pkg::SAT_MIN) begin
      res_nxt.rotated_y = pra_pkg::RES_MIN;
      res_nxt.saturated = 1'b1;
    end else begin
      res_nxt.rotated_y = $signed(vy[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      geo_r[0] <= in_d.geo;
      r1_c_r   <= $signed(c34[31:0]);
      r1_s_r   <= $signed(s34[31:0]);
    end
    if (rdy[1]) begin
      geo_r[1] <= geo_r[0];
      r2_cdx_r <= 65'(r1_c_r) * 65'(geo_r[0].dx);
      r2_sdy_r <= 65'(r1_s_r) * 65'(geo_r[0].dy);
      r2_cdy_r <= 65'(r1_c_r) * 65'(geo_r[0].dy);
      r2_sdx_r <= 65'(r1_s_r) * 65'(geo_r[0].dx);
    end
    if (rdy[2]) begin
      geo_r[2] <= geo_r[1];
      r3_sx_r  <= 66'(r2_cdx_r) + 66'(r2_sdy_r);
      r3_sy_r  <= 66'(r2_cdy_r) - 66'(r2_sdx_r);
    end
    if (rdy[3]) begin
      geo_r[3] <= geo_r[2];
      r4_tx_r  <= $signed(sxr[37:0]);
      r4_ty_r  <= $signed(syr[37:0]);
    end
    if (rdy[4]) begin
      geo_r[4] <= geo_r[3];
      r5_res_r <= res_nxt;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_d     = r5_res_r;

endmodule

`default_nettype wire

// ===== sv/point_rotation_about_center.sv =====
// Top level: rotates a Q16.16 point about a center by an angle in degrees.
// Pipeline: angle front end, one CORDIC cell per stage (clamped at 32 stages), rotation back end.
// Throughput: one transaction per cycle while the output is not stalled; each stage is a register with its own valid.
// A stage holds only when the one ahead is full and stalled, so bubbles close up.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`default_nettype none
`include "point_rotation_about_center_macros.svh"

module point_rotation_about_center #(
  parameter int CORDIC_STAGES = pra_pkg::CORDIC_STAGES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pra_in_if.sink    in_pt,
  pra_out_if.source out_res
);

  localparam int NCELL = (CORDIC_STAGES > pra_pkg::MAX_STAGES) ?
                         pra_pkg::MAX_STAGES : CORDIC_STAGES;

  pra_pkg::geo_t in_geo;
  pra_pkg::ang_t ang;
  logic          ang_v;
  logic          ang_rdy;

  logic [NCELL:0] c_v;
  logic [NCELL:0] c_rdy;
  pra_pkg::crd_t  c_d [NCELL+1];

  pra_pkg::res_t res;
  logic          rot_v;

  assign in_geo.dx = 33'(in_pt.point_x) - 33'(in_pt.center_x);
  assign in_geo.dy = 33'(in_pt.point_y) - 33'(in_pt.center_y);
  assign in_geo.cx = in_pt.center_x;
  assign in_geo.cy = in_pt.center_y;

  pra_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pt.valid),
    .in_ready  (in_pt.ready),
    .angle_deg (in_pt.angle_deg),
    .in_geo    (in_geo),
    .out_valid (ang_v),
    .out_ready (ang_rdy),
    .out_ang   (ang)
  );

  assign c_v[0]      = ang_v;
  assign ang_rdy     = c_rdy[0];
  assign c_d[0].x    = pra_pkg::CORDIC_GAIN;
  assign c_d[0].y    = '0;
  assign c_d[0].z    = 33'(ang.z);
  assign c_d[0].flip = ang.flip;
  assign c_d[0].geo  = ang.geo;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    pra_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_v[g]),
      .in_ready  (c_rdy[g]),
      .in_d      (c_d[g]),
      .out_valid (c_v[g+1]),
      .out_ready (c_rdy[g+1]),
      .out_d     (c_d[g+1])
    );
  end

  pra_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_v[NCELL]),
    .in_ready  (c_rdy[NCELL]),
    .in_d      (c_d[NCELL]),
    .out_valid (rot_v),
    .out_ready (out_res.ready),
    .out_d     (res)
  );

  assign out_res.valid     = rot_v;
  assign out_res.rotated_x = res.rotated_x;
  assign out_res.rotated_y = res.rotated_y;
  assign out_res.saturated = res.saturated;

  `PRA_ASSERT_RST(a_rst_clear, (!rst_n |=> (!out_res.valid && !ang_v)), "valid after reset")
  `PRA_ASSERT(a_empty_ready, (!out_res.valid |-> in_pt.ready), "stall with empty output")
  `PRA_ASSERT(a_fold_range, (ang_v |-> (ang.z <= pra_pkg::FOLD_LIM && ang.z >= -pra_pkg::FOLD_LIM)), "angle fold out of range")
  `PRA_ASSERT(a_sat_value, ((out_res.valid && out_res.saturated) |-> (out_res.rotated_x == pra_pkg::RES_MAX || out_res.rotated_x == pra_pkg::RES_MIN || out_res.rotated_y == pra_pkg::RES_MAX || out_res.rotated_y == pra_pkg::RES_MIN)), "saturation flag without clipped value")

endmodule

`default_nettype wire
